// ===== design/dmv_pkg.sv =====
// Shared constants, register indexes and operand type for the dual motor
// velocity loop. No dependencies.
`timescale 1ns / 1ps

package dmv_pkg;

    localparam int VEL_SCALE_DEF   = 357;
    localparam int SEND_PERIOD_DEF = 6;

    localparam logic [31:0] FB_BASE  = 32'h0000_0200;
    localparam logic [9:0]  CMD_ID   = 10'h200;
    localparam logic [7:0]  HDR_BYTE = 8'hAA;
    localparam logic [7:0]  STS_OK   = 8'h11;
    localparam logic [7:0]  TRL_BYTE = 8'h55;
    localparam logic [5:0]  MAX_LEN  = 6'd8;

    // 1.2 in Q16.16.
    localparam logic signed [17:0] SCALE_1P2 = 18'sd78643;
    localparam int SUM_LIM  = 16777216;
    localparam int TAU_LIM  = 655360;
    // 0.246 in Q16.16 times the 80 current units that make one code step.
    localparam logic [20:0] DIV_CONST = 21'd1289760;
    localparam logic [15:0] CODE_LIM  = 16'd16384;

    localparam logic [2:0] REG_A_ID     = 3'd0;
    localparam logic [2:0] REG_B_ID     = 3'd1;
    localparam logic [2:0] REG_A_TARGET = 3'd2;
    localparam logic [2:0] REG_A_FF     = 3'd3;
    localparam logic [2:0] REG_A_GAIN   = 3'd4;
    localparam logic [2:0] REG_B_TARGET = 3'd5;
    localparam logic [2:0] REG_B_FF     = 3'd6;
    localparam logic [2:0] REG_B_GAIN   = 3'd7;

    typedef struct packed {
        logic signed [15:0] rpm;
        logic signed [31:0] target;
        logic signed [31:0] feedforward;
        logic signed [31:0] gain;
    } dmv_operands_t;

endpackage

// ===== design/dmv_motor_core.sv =====
// Bit-serial torque-to-current-code unit for one motor at a time.
// Depends on dmv_pkg.
`timescale 1ns / 1ps

module dmv_motor_core
    import dmv_pkg::*;
#(
    parameter int VEL_SCALE = VEL_SCALE_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  dmv_operands_t      ops,
    output logic               done,
    output logic signed [15:0] code
);

    localparam int VS_W  = $clog2(VEL_SCALE + 1) + 1;
    localparam logic signed [VS_W-1:0] VS = VS_W'(VEL_SCALE);
    localparam int SPD_W = 16 + VS_W;
    localparam int EW    = (SPD_W > 32 ? SPD_W : 32) + 1;
    localparam int PW    = EW + 32;

    localparam logic [3:0] C_IDLE = 4'd0;
    localparam logic [3:0] C_SPD  = 4'd1;
    localparam logic [3:0] C_ERR  = 4'd2;
    localparam logic [3:0] C_MUL  = 4'd3;
    localparam logic [3:0] C_SUM  = 4'd4;
    localparam logic [3:0] C_SCL  = 4'd5;
    localparam logic [3:0] C_CLP  = 4'd6;
    localparam logic [3:0] C_DIV  = 4'd7;
    localparam logic [3:0] C_FIN  = 4'd8;

    localparam logic [5:0] MUL_LAST = 6'd31;
    localparam logic [5:0] DIV_LAST = 6'd35;

    logic [3:0]               state_reg;
    logic [5:0]               cnt_reg;
    dmv_operands_t            op_reg;
    logic signed [SPD_W-1:0]  spd_reg;
    logic signed [PW-1:0]     mcand_reg;
    logic [31:0]              mplier_reg;
    logic signed [PW-1:0]     acc_reg;
    logic signed [25:0]       tau_reg;
    logic signed [43:0]       sp_reg;
    logic                     neg_reg;
    logic [35:0]              dvd_reg;
    logic [20:0]              rem_reg;

    logic signed [EW-1:0]     err;
    logic signed [PW-1:0]     sum;
    logic signed [25:0]       tau_next;
    logic signed [43:0]       scaled;
    logic signed [20:0]       tq;
    logic [20:0]              tq_mag;
    logic [21:0]              trial;
    logic                     qbit;
    logic [15:0]              mag;

    always_comb
    begin
        err = EW'(op_reg.target) - EW'(spd_reg);
        sum = (acc_reg >>> 16) + PW'(op_reg.feedforward);
        if (sum > PW'(SUM_LIM))
            tau_next = 26'(SUM_LIM);
        else if (sum < -PW'(SUM_LIM))
            tau_next = -26'(SUM_LIM);
        else
            tau_next = sum[25:0];
        scaled = sp_reg >>> 16;
        if (scaled > 44'(TAU_LIM))
            tq = 21'(TAU_LIM);
        else if (scaled < -44'(TAU_LIM))
            tq = -21'(TAU_LIM);
        else
            tq = scaled[20:0];
        tq_mag = tq[20] ? 21'(-tq) : 21'(tq);
        trial = {rem_reg, dvd_reg[35]};
        qbit = (trial >= {1'b0, DIV_CONST});
        mag = (dvd_reg > 36'(CODE_LIM)) ? CODE_LIM : dvd_reg[15:0];
    end

    assign done = (state_reg == C_FIN);
    assign code = neg_reg ? -$signed(mag) : $signed(mag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                        state_reg <= C_SPD;
                end
                C_SPD:  state_reg <= C_ERR;
                C_ERR:
                begin
                    cnt_reg   <= '0;
                    state_reg <= C_MUL;
                end
                C_MUL:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == MUL_LAST)
                        state_reg <= C_SUM;
                end
                C_SUM:  state_reg <= C_SCL;
                C_SCL:  state_reg <= C_CLP;
                C_CLP:
                begin
                    cnt_reg   <= '0;
                    state_reg <= C_DIV;
                end
                C_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == DIV_LAST)
                        state_reg <= C_FIN;
                end
                C_FIN:  state_reg <= C_IDLE;
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                    op_reg <= ops;
            end
            C_SPD:
            begin
                spd_reg <= SPD_W'(op_reg.rpm) * SPD_W'(VS);
            end
            C_ERR:
            begin
                mcand_reg  <= PW'(err);
                mplier_reg <= op_reg.gain;
                acc_reg    <= '0;
            end
            C_MUL:
            begin
                // The top bit of the gain carries negative weight.
                if (mplier_reg[0])
                    acc_reg <= (cnt_reg == MUL_LAST) ? acc_reg - mcand_reg
                                                     : acc_reg + mcand_reg;
                mcand_reg  <= mcand_reg <<< 1;
                mplier_reg <= mplier_reg >> 1;
            end
            C_SUM:
            begin
                tau_reg <= tau_next;
            end
            C_SCL:
            begin
                sp_reg <= 44'(tau_reg) * 44'(SCALE_1P2);
            end
            C_CLP:
            begin
                neg_reg <= tq[20];
                dvd_reg <= {tq_mag[19:0], 16'b0};
                rem_reg <= '0;
            end
            C_DIV:
            begin
                rem_reg <= qbit ? 21'(trial - {1'b0, DIV_CONST}) : trial[20:0];
                dvd_reg <= {dvd_reg[34:0], qbit};
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == C_IDLE))
        else $error("start while the unit is busy");

    a_tau_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_SCL) |-> (tau_reg <= 26'(SUM_LIM) && tau_reg >= -26'(SUM_LIM)))
        else $error("torque sum left its clamp range");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (code <= $signed(CODE_LIM) && code >= -$signed(CODE_LIM)))
        else $error("current code out of range");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_DIV) |-> (rem_reg < DIV_CONST))
        else $error("divider remainder not reduced");
`endif

endmodule

// ===== design/dual_motor_velocity_current_command.sv =====
// Top level of the dual motor velocity loop: stream ports, register file,
// feedback capture and tick sequencing. Depends on dmv_pkg and dmv_motor_core.
`timescale 1ns / 1ps

// Usage. Input items arrive on the s_axis channel. tuser set means the item is a
// bridge frame: it is checked (header, status, trailer, length) and its rpm word
// is stored for each motor whose id plus 0x200 equals the frame id. A frame never
// gives a result. tuser clear means a control tick: the torque and current
// code of motor A and then of motor B are worked out by one shared bit-serial
// unit, and every SEND_PERIOD-th tick the command item for CAN id 0x200 is
// placed in the output register.
// A tick holds s_axis_tready low until it ends: each motor has a launch state
// and then passes through the unit for speed, error load, the serial gain
// multiplier, sum, scaling, clamping, the serial divider and hand-off. A
// sending tick then waits in an emit state until the output register is free
// and loads it, which makes its command item valid.
// The output register holds the command until m_axis_tready takes it; the next
// items are still accepted, and only a later sending tick waits at its end for
// the register to be free.
// Reset clears the stored speeds and the tick counter, sets the motor ids to 1
// and 2 and the targets, gains and feedforward terms to zero. Configuration
// writes should be made while no tick is in progress.

module dual_motor_velocity_current_command
    import dmv_pkg::*;
#(
    parameter int VEL_SCALE   = VEL_SCALE_DEF,
    parameter int SEND_PERIOD = SEND_PERIOD_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // header_byte, status_byte, data_length, trailer_byte, frame_id, payload, zero fill
    input  logic [127:0] s_axis_tdata,
    // opcode
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // command_id, motor_a_current_code, motor_b_current_code, frame_bytes, zero fill
    output logic [111:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);

    localparam int TW = (SEND_PERIOD > 1) ? $clog2(SEND_PERIOD) : 1;

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_LA   = 3'd1;
    localparam logic [2:0] T_WA   = 3'd2;
    localparam logic [2:0] T_LB   = 3'd3;
    localparam logic [2:0] T_WB   = 3'd4;
    localparam logic [2:0] T_EMIT = 3'd5;

    logic [2:0]         state_reg;
    logic [TW-1:0]      tick_reg;
    logic [3:0]         a_id_reg;
    logic [3:0]         b_id_reg;
    logic signed [31:0] a_target_reg;
    logic signed [31:0] a_ff_reg;
    logic signed [31:0] a_gain_reg;
    logic signed [31:0] b_target_reg;
    logic signed [31:0] b_ff_reg;
    logic signed [31:0] b_gain_reg;
    logic signed [15:0] a_rpm_reg;
    logic signed [15:0] b_rpm_reg;
    logic signed [15:0] a_code_reg;
    logic               out_valid_reg;
    logic [111:0]       out_data_reg;

    logic [7:0]         header_byte;
    logic [7:0]         status_byte;
    logic [5:0]         data_length;
    logic [7:0]         trailer_byte;
    logic [31:0]        frame_id;
    logic [63:0]        payload;
    logic               frame_ok;
    logic               in_accept;
    logic               send_tick;
    logic               emit_ok;

    dmv_operands_t      ops;
    logic               core_start;
    logic               core_done;
    logic signed [15:0] core_code;

    assign header_byte  = s_axis_tdata[7:0];
    assign status_byte  = s_axis_tdata[15:8];
    assign data_length  = s_axis_tdata[21:16];
    assign trailer_byte = s_axis_tdata[29:22];
    assign frame_id     = s_axis_tdata[61:30];
    assign payload      = s_axis_tdata[125:62];

    assign frame_ok = (header_byte == HDR_BYTE) && (status_byte == STS_OK)
                   && (data_length <= MAX_LEN) && (trailer_byte == TRL_BYTE);

    assign s_axis_tready = (state_reg == T_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign send_tick     = (32'(tick_reg) + 32'd1 >= 32'(SEND_PERIOD));

    // The output register is free when empty or when its item leaves this cycle.
    assign emit_ok = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Operands follow the motor being launched; the unit latches them at start.
    always_comb
    begin
        if (state_reg == T_LB)
            ops = '{rpm: b_rpm_reg, target: b_target_reg,
                    feedforward: b_ff_reg, gain: b_gain_reg};
        else
            ops = '{rpm: a_rpm_reg, target: a_target_reg,
                    feedforward: a_ff_reg, gain: a_gain_reg};
    end

    assign core_start = (state_reg == T_LA) || (state_reg == T_LB);

    dmv_motor_core #(
        .VEL_SCALE (VEL_SCALE)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (core_start),
        .ops   (ops),
        .done  (core_done),
        .code  (core_code)
    );

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_id_reg     <= 4'd1;
            b_id_reg     <= 4'd2;
            a_target_reg <= '0;
            a_ff_reg     <= '0;
            a_gain_reg   <= '0;
            b_target_reg <= '0;
            b_ff_reg     <= '0;
            b_gain_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_A_ID:     a_id_reg     <= cfg_wdata[3:0];
                REG_B_ID:     b_id_reg     <= cfg_wdata[3:0];
                REG_A_TARGET: a_target_reg <= cfg_wdata;
                REG_A_FF:     a_ff_reg     <= cfg_wdata;
                REG_A_GAIN:   a_gain_reg   <= cfg_wdata;
                REG_B_TARGET: b_target_reg <= cfg_wdata;
                REG_B_FF:     b_ff_reg     <= cfg_wdata;
                REG_B_GAIN:   b_gain_reg   <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Feedback capture: a good frame can update both motors when the ids match.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rpm_reg <= '0;
            b_rpm_reg <= '0;
        end
        else if (in_accept && s_axis_tuser && frame_ok)
        begin
            if (32'(a_id_reg) + FB_BASE == frame_id)
                a_rpm_reg <= payload[47:32];
            if (32'(b_id_reg) + FB_BASE == frame_id)
                b_rpm_reg <= payload[47:32];
        end
    end

    // Tick sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == T_EMIT && emit_ok)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                T_IDLE:
                begin
                    if (in_accept && !s_axis_tuser)
                        state_reg <= T_LA;
                end
                T_LA: state_reg <= T_WA;
                T_WA:
                begin
                    if (core_done)
                        state_reg <= T_LB;
                end
                T_LB: state_reg <= T_WB;
                T_WB:
                begin
                    if (core_done)
                    begin
                        if (send_tick)
                        begin
                            tick_reg  <= '0;
                            state_reg <= T_EMIT;
                        end
                        else
                        begin
                            tick_reg  <= tick_reg + TW'(1);
                            state_reg <= T_IDLE;
                        end
                    end
                end
                T_EMIT:
                begin
                    if (emit_ok)
                        state_reg <= T_IDLE;
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    // Codes are payload; the motor B code is held by the unit until it restarts.
    always_ff @(posedge clk)
    begin
        if (state_reg == T_WA && core_done)
            a_code_reg <= core_code;
        if (state_reg == T_EMIT && emit_ok)
        begin
            out_data_reg[9:0]     <= CMD_ID;
            out_data_reg[25:10]   <= a_code_reg;
            out_data_reg[41:26]   <= core_code;
            out_data_reg[105:42]  <= {a_code_reg, core_code, 32'b0};
            out_data_reg[111:106] <= '0;
        end
    end

`ifndef SYNTH
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("command item changed while stalled");

    a_out_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[9:0] == CMD_ID))
        else $error("command id wrong");

    a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(tick_reg) < 32'(SEND_PERIOD))
        else $error("tick counter out of range");
`endif

endmodule
